/* design/epr_pkg.sv */
// Shared types, constants and helpers for the e-paper refresh policy block.
package epr_pkg;

   localparam int MAX_FRAME_BYTES = 65536;
   localparam int COUNT_BITS      = 8;

   localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
   localparam int MEM_AW = ADDR_W + 1;
   localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
   localparam int FB_W   = 17;
   localparam int LEN_W  = (POS_W > FB_W) ? POS_W : FB_W;
   localparam int CMP_W  = COUNT_BITS + 9;
   localparam int IDX_W  = 3;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LEN_W-1:0]      LEN_MAX = LEN_W'(MAX_FRAME_BYTES);

   localparam logic [FB_W-1:0] FRAME_BYTES_RST = FB_W'(48000);
   localparam logic [7:0]      FAST_LIMIT_RST  = 8'd4;
   localparam logic [7:0]      PAGE_LIMIT_RST  = 8'd8;
   localparam logic [7:0]      CLEAN_LIMIT_RST = 8'd4;

   typedef enum logic [2:0] {
      CMD_BYTE       = 3'd0,
      CMD_PLAN       = 3'd1,
      CMD_COMMIT     = 3'd2,
      CMD_GRAY       = 3'd3,
      CMD_RESYNC     = 3'd4,
      CMD_INVALIDATE = 3'd5,
      CMD_RESTART    = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_FULL = 2'd0,
      MODE_HALF = 2'd1,
      MODE_FAST = 2'd2
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_ENABLED     = 3'd0,
      CSR_FRAME_BYTES = 3'd1,
      CSR_FAST_CLEAN  = 3'd2,
      CSR_PAGE_CEIL   = 3'd3,
      CSR_CLEANS_FULL = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] pixel_byte;
      logic [1:0] mode_request;
      logic       hint;
      logic       inverted;
      logic       async_refresh;
      logic       allow_skip;
   } req_type;

   typedef struct packed {
      mode_type   out_mode;
      logic       skip;
      logic [7:0] fast_since_clean;
      logic [7:0] cleans_since_full;
      logic       gray_on_glass;
      logic       shadow_ok;
      logic       frame_ready;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [MEM_AW-1:0] rd_addr;
      logic [7:0]        data;
   } mem_req_type;

   function automatic logic [7:0] cnt_out(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS+7:0] wide;
      wide = {8'b0, c};
      return wide[7:0];
   endfunction

endpackage

/* design/epr_frame_mem.sv */
// Two-bank frame store: writes the pending byte, reads the shadow byte, flags a mismatch.
module epr_frame_mem
   import epr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic        mismatch
);

   logic [7:0] store [2*MAX_FRAME_BYTES];

   logic [7:0] rd_data_ff;
   logic [7:0] px_ff;
   logic       cmp_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store[mem_req.wr_addr] <= mem_req.data;
      end
      rd_data_ff <= store[mem_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      px_ff <= mem_req.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= mem_req.wr_en;
      end
   end

   // write and read always hit opposite banks, so no bypass is needed
   assign mismatch = cmp_valid_ff && (rd_data_ff != px_ff);

endmodule

/* design/epr_policy.sv */
// Refresh policy control state, configuration registers and result formation.
module epr_policy
   import epr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [FB_W-1:0]  csr_wdata,
   input  logic             req_fire,
   input  req_type          req,
   input  logic             mismatch,
   output mem_req_type      mem_req,
   output rsp_type          rsp
);

   logic                  enabled_ff, enabled_in;
   logic [FB_W-1:0]       frame_bytes_ff, frame_bytes_in;
   logic [7:0]            fast_clean_ff, fast_clean_in;
   logic [7:0]            page_ceil_ff, page_ceil_in;
   logic [7:0]            cleans_full_ff, cleans_full_in;

   logic                  bank_ff, bank_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  differs_ff, differs_in;
   logic                  complete_ff, complete_in;
   logic                  shadow_valid_ff, shadow_valid_in;
   logic                  polarity_ff, polarity_in;
   logic                  gray_ff, gray_in;
   logic                  first_ff, first_in;
   logic [COUNT_BITS-1:0] fast_cnt_ff, fast_cnt_in;
   logic [COUNT_BITS-1:0] clean_cnt_ff, clean_cnt_in;

   logic [LEN_W-1:0]      fb_ext;
   logic [LEN_W-1:0]      frame_len;
   logic [LEN_W-1:0]      pos_ext;
   logic                  byte_take;
   logic                  restart;
   logic                  differs_now;
   mode_type              mode_eff;
   mode_type              plan_mode;
   logic                  plan_skip;
   logic                  fast_hit_ui;
   logic                  fast_hit_page;
   logic                  clean_hit;
   logic                  is_plan;
   logic [POS_W-1:0]      pos_next;

   // effective frame length, clamped to [1, MAX_FRAME_BYTES]
   always_comb begin
      fb_ext = LEN_W'(frame_bytes_ff);
      if (frame_bytes_ff == '0) begin
         frame_len = LEN_W'(1);
      end else if (fb_ext > LEN_MAX) begin
         frame_len = LEN_MAX;
      end else begin
         frame_len = fb_ext;
      end
   end

   assign pos_ext  = LEN_W'(pos_ff);
   assign pos_next = pos_ff + POS_W'(1);

   always_comb begin
      if (req.mode_request == MODE_FAST) begin
         mode_eff = MODE_FAST;
      end else if (req.mode_request == MODE_HALF) begin
         mode_eff = MODE_HALF;
      end else begin
         mode_eff = MODE_FULL;
      end
   end

   // forward the compare of a byte still in flight
   assign differs_now = differs_ff || mismatch;

   assign fast_hit_ui   = ({8'b0, fast_cnt_ff} >= {{COUNT_BITS{1'b0}}, fast_clean_ff});
   assign fast_hit_page = ({8'b0, fast_cnt_ff} >= {{COUNT_BITS{1'b0}}, page_ceil_ff});

   always_comb begin
      plan_mode = mode_eff;
      clean_hit = 1'b0;
      if (enabled_ff) begin
         if (mode_eff == MODE_FAST) begin
            if (first_ff || (!req.hint && gray_ff) || (!req.hint && fast_hit_ui) ||
                (req.hint && fast_hit_page)) begin
               plan_mode = MODE_HALF;
            end
         end
         clean_hit = ({9'b0, clean_cnt_ff} + CMP_W'(1)) >=
                     {{COUNT_BITS{1'b0}}, 1'b0, cleans_full_ff};
         if (plan_mode == MODE_HALF && cleans_full_ff != 8'd0 && clean_hit) begin
            plan_mode = MODE_FULL;
         end
      end
      plan_skip = enabled_ff && plan_mode == MODE_FAST && !req.hint && !req.async_refresh &&
                  req.allow_skip && shadow_valid_ff && (polarity_ff == req.inverted) &&
                  complete_ff && !differs_now;
   end

   always_comb begin
      enabled_in      = enabled_ff;
      frame_bytes_in  = frame_bytes_ff;
      fast_clean_in   = fast_clean_ff;
      page_ceil_in    = page_ceil_ff;
      cleans_full_in  = cleans_full_ff;
      bank_in         = bank_ff;
      pos_in          = pos_ff;
      complete_in     = complete_ff;
      shadow_valid_in = shadow_valid_ff;
      polarity_in     = polarity_ff;
      gray_in         = gray_ff;
      first_in        = first_ff;
      fast_cnt_in     = fast_cnt_ff;
      clean_cnt_in    = clean_cnt_ff;
      restart         = 1'b0;
      byte_take       = 1'b0;
      is_plan         = 1'b0;

      if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_ENABLED:     enabled_in = csr_wdata[0];
            CSR_FRAME_BYTES: begin
               frame_bytes_in  = csr_wdata;
               restart         = 1'b1;
               shadow_valid_in = 1'b0;
            end
            CSR_FAST_CLEAN:  fast_clean_in  = csr_wdata[7:0];
            CSR_PAGE_CEIL:   page_ceil_in   = csr_wdata[7:0];
            CSR_CLEANS_FULL: cleans_full_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      if (req_fire) begin
         case (cmd_type'(req.command))
            CMD_BYTE: begin
               if (!complete_ff && pos_ext < frame_len) begin
                  byte_take = 1'b1;
                  pos_in    = pos_next;
                  if (LEN_W'(pos_next) >= frame_len) begin
                     complete_in = 1'b1;
                  end
               end
            end
            CMD_PLAN: is_plan = 1'b1;
            CMD_COMMIT: begin
               if (enabled_ff) begin
                  first_in = 1'b0;
                  if (mode_eff == MODE_FAST) begin
                     fast_cnt_in = (fast_cnt_ff == CNT_MAX) ? CNT_MAX
                                                            : fast_cnt_ff + COUNT_BITS'(1);
                  end else if (mode_eff == MODE_HALF) begin
                     fast_cnt_in  = '0;
                     clean_cnt_in = (clean_cnt_ff == CNT_MAX) ? CNT_MAX
                                                              : clean_cnt_ff + COUNT_BITS'(1);
                     gray_in      = 1'b0;
                  end else begin
                     fast_cnt_in  = '0;
                     clean_cnt_in = '0;
                     gray_in      = 1'b0;
                  end
                  if (req.async_refresh || !complete_ff) begin
                     shadow_valid_in = 1'b0;
                  end else begin
                     bank_in         = !bank_ff;
                     shadow_valid_in = 1'b1;
                     polarity_in     = req.inverted;
                     restart         = 1'b1;
                  end
               end
            end
            CMD_GRAY: begin
               if (enabled_ff) begin
                  gray_in = 1'b1;
               end
            end
            CMD_RESYNC: begin
               if (enabled_ff) begin
                  if (!complete_ff) begin
                     shadow_valid_in = 1'b0;
                  end else begin
                     bank_in         = !bank_ff;
                     shadow_valid_in = 1'b1;
                     polarity_in     = req.inverted;
                     restart         = 1'b1;
                  end
               end
            end
            CMD_INVALIDATE: shadow_valid_in = 1'b0;
            CMD_RESTART:    restart = 1'b1;
            default: ;
         endcase
      end

      if (restart) begin
         pos_in      = '0;
         complete_in = 1'b0;
      end
      // a restart drops a compare still in flight from the old load
      differs_in = restart ? 1'b0 : differs_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff      <= 1'b1;
         frame_bytes_ff  <= FRAME_BYTES_RST;
         fast_clean_ff   <= FAST_LIMIT_RST;
         page_ceil_ff    <= PAGE_LIMIT_RST;
         cleans_full_ff  <= CLEAN_LIMIT_RST;
         bank_ff         <= 1'b0;
         pos_ff          <= '0;
         differs_ff      <= 1'b0;
         complete_ff     <= 1'b0;
         shadow_valid_ff <= 1'b0;
         polarity_ff     <= 1'b0;
         gray_ff         <= 1'b0;
         first_ff        <= 1'b1;
         fast_cnt_ff     <= '0;
         clean_cnt_ff    <= '0;
      end else begin
         enabled_ff      <= enabled_in;
         frame_bytes_ff  <= frame_bytes_in;
         fast_clean_ff   <= fast_clean_in;
         page_ceil_ff    <= page_ceil_in;
         cleans_full_ff  <= cleans_full_in;
         bank_ff         <= bank_in;
         pos_ff          <= pos_in;
         differs_ff      <= differs_in;
         complete_ff     <= complete_in;
         shadow_valid_ff <= shadow_valid_in;
         polarity_ff     <= polarity_in;
         gray_ff         <= gray_in;
         first_ff        <= first_in;
         fast_cnt_ff     <= fast_cnt_in;
         clean_cnt_ff    <= clean_cnt_in;
      end
   end

   always_comb begin
      mem_req.wr_en   = byte_take;
      mem_req.wr_addr = {!bank_ff, pos_ff[ADDR_W-1:0]};
      mem_req.rd_addr = {bank_ff, pos_ff[ADDR_W-1:0]};
      mem_req.data    = req.pixel_byte;
   end

   always_comb begin
      rsp.out_mode          = is_plan ? plan_mode : MODE_FULL;
      rsp.skip              = is_plan && plan_skip;
      rsp.fast_since_clean  = cnt_out(fast_cnt_in);
      rsp.cleans_since_full = cnt_out(clean_cnt_in);
      rsp.gray_on_glass     = gray_in;
      rsp.shadow_ok         = shadow_valid_in;
      rsp.frame_ready       = complete_in;
   end

   a_complete_has_bytes: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> pos_ff != '0)
      else $error("frame complete with no bytes loaded");

   a_write_only_while_loading: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (req_fire && !complete_ff && pos_ext < frame_len))
      else $error("frame store written outside a load");

   a_shadow_from_full_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(shadow_valid_ff) |-> $past(complete_ff))
      else $error("shadow validated from an incomplete frame");

   a_swap_restarts_load: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> (pos_ff == '0 && !complete_ff && !differs_ff))
      else $error("bank swap did not restart the frame load");

endmodule

/* design/epr_rsp_queue.sv */
// Two-entry result queue between the policy logic and the response channel.
module epr_rsp_queue
   import epr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    not_full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rsp_type pop_data
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign not_full  = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("result queue overflow");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_ptr_count_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result queue pointers disagree with count");

endmodule

/* design/epaper_refresh_mode_policy_core.sv */
// Each result is registered into the result queue as its request is accepted. One request per
// cycle is taken while the queue has room; the frame store does one byte write and one read a cycle.
// A two-entry result queue lets requests keep flowing while one result waits.
// Reset is synchronous: control and configuration take their defaults at once, no clearing pass.
// Frame store contents are undefined after reset; a skip needs a fully loaded shadow.
module epaper_refresh_mode_policy_core
   import epr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [FB_W-1:0]  csr_wdata,

   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_command,
   input  logic [7:0]       req_pixel_byte,
   input  logic [1:0]       req_mode_request,
   input  logic             req_hint,
   input  logic             req_inverted,
   input  logic             req_async_refresh,
   input  logic             req_allow_skip,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_out_mode,
   output logic             rsp_skip,
   output logic [7:0]       rsp_fast_since_clean,
   output logic [7:0]       rsp_cleans_since_full,
   output logic             rsp_gray_on_glass,
   output logic             rsp_shadow_ok,
   output logic             rsp_frame_ready
);

   req_type     req;
   rsp_type     rsp_new;
   rsp_type     rsp_head;
   mem_req_type mem_req;
   logic        mismatch;
   logic        req_fire;
   logic        q_not_full;

   assign csr_ready = 1'b1;
   assign req_ready = q_not_full;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      req.command       = req_command;
      req.pixel_byte    = req_pixel_byte;
      req.mode_request  = req_mode_request;
      req.hint          = req_hint;
      req.inverted      = req_inverted;
      req.async_refresh = req_async_refresh;
      req.allow_skip    = req_allow_skip;
   end

   epr_policy u_policy (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_fire  (req_fire),
      .req       (req),
      .mismatch  (mismatch),
      .mem_req   (mem_req),
      .rsp       (rsp_new)
   );

   epr_frame_mem u_frame_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .mismatch (mismatch)
   );

   epr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (rsp_new),
      .not_full  (q_not_full),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_head)
   );

   assign rsp_out_mode          = rsp_head.out_mode;
   assign rsp_skip              = rsp_head.skip;
   assign rsp_fast_since_clean  = rsp_head.fast_since_clean;
   assign rsp_cleans_since_full = rsp_head.cleans_since_full;
   assign rsp_gray_on_glass     = rsp_head.gray_on_glass;
   assign rsp_shadow_ok         = rsp_head.shadow_ok;
   assign rsp_frame_ready       = rsp_head.frame_ready;

endmodule
